[design/aabb_player_collision_step_assert.svh]
// Assertion macros shared by the collision step RTL.
`ifndef AABB_PLAYER_COLLISION_STEP_ASSERT_SVH
`define AABB_PLAYER_COLLISION_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define APCS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define APCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[design/apcs_pkg.sv]
// Shared types, codes, constants and helpers of the collision step.
package apcs_pkg;

  localparam int MAX_BOXES_DEF = 64;

  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_JUMP   = 2'd1;
  localparam logic [1:0] MODE_LOAD   = 2'd2;

  localparam logic [2:0] REG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] REG_GRAVITY     = 3'd1;
  localparam logic [2:0] REG_JUMP_SPEED  = 3'd2;
  localparam logic [2:0] REG_HALF_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HALF_HEIGHT = 3'd4;
  localparam logic [2:0] REG_HALF_DEPTH  = 3'd5;
  localparam logic [2:0] REG_BOX_COUNT   = 3'd6;

  localparam logic [30:0]        MOVE_SPEED_RST  = 31'd327680;
  localparam logic signed [31:0] GRAVITY_RST     = -32'sd642253;
  localparam logic [30:0]        JUMP_SPEED_RST  = 31'd327680;
  localparam logic [30:0]        HALF_WIDTH_RST  = 31'd19661;
  localparam logic [30:0]        HALF_HEIGHT_RST = 31'd58982;
  localparam logic [30:0]        HALF_DEPTH_RST  = 31'd19661;
  localparam logic [6:0]         BOX_COUNT_RST   = 7'd0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_KIN,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } box_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vs;
    logic               gnd;
  } player_t;

  // Clamp a wide signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[design/aabb_player_collision_step.sv]
// Top level of the player collision step: ports, control and cell row.
//
//  channel  direction  handshake               payload
//  s_*      in         s_tvalid / s_tready     s_tuser mode, s_tdata item fields
//  m_*      out        m_tvalid / m_tready     m_tdata pos_x..z, vel_y, grounded
//  cfg_*    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Load, jump and unused-mode items register their result in the cycle of their transfer.
// An update runs through the kinematics stages, then the player walks the row
// of box cells, one cycle per cell, then the result is registered for output
// once that is free. One item is in work at a time.
// Reset (rst, synchronous) clears control, speed and grounded and loads the
// register defaults; box cells hold whatever they held until loaded.
// A stalled output holds the result; the input is refused until it drains.
module aabb_player_collision_step #(
  parameter int MAX_BOXES = apcs_pkg::MAX_BOXES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,   // mode
  // slot, coord_x, coord_y, coord_z, upper_x, upper_y, upper_z,
  // move_x, move_z, delta_t, zero pad
  input  logic [247:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pos_z, vel_y, grounded, zero pad
  output logic [135:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CW = $clog2(MAX_BOXES + 1);

  apcs_pkg::state_t   state, state_next;
  logic [CW-1:0]      cnt;
  logic               acc, out_free, is_upd, kin_done, produce;
  logic [1:0]         mode;
  logic [5:0]         slot;
  apcs_pkg::box_t     ld_box;

  logic [30:0]        move_speed, jump_speed, half_width, half_height, half_depth;
  logic signed [31:0] gravity;
  logic [6:0]         box_count;

  logic signed [31:0] vertical_speed;
  logic               on_ground;

  apcs_pkg::player_t  kin_res, res;
  apcs_pkg::player_t  chain [MAX_BOXES+1];

  logic signed [31:0] out_px, out_py, out_pz, out_vs;
  logic               out_gnd;

  assign mode     = s_tuser;
  assign slot     = s_tdata[5:0];
  assign ld_box.min_x = s_tdata[37:6];
  assign ld_box.min_y = s_tdata[69:38];
  assign ld_box.min_z = s_tdata[101:70];
  assign ld_box.max_x = s_tdata[133:102];
  assign ld_box.max_y = s_tdata[165:134];
  assign ld_box.max_z = s_tdata[197:166];
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign is_upd   = mode == apcs_pkg::MODE_UPDATE;
  assign produce  = (acc && !is_upd) || (state == apcs_pkg::S_DONE && out_free);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      apcs_pkg::S_IDLE: if (acc && is_upd) state_next = apcs_pkg::S_KIN;
      apcs_pkg::S_KIN:  if (kin_done) state_next = apcs_pkg::S_WALK;
      apcs_pkg::S_WALK: if (cnt == CW'(MAX_BOXES)) state_next = apcs_pkg::S_DONE;
      apcs_pkg::S_DONE: if (out_free) state_next = apcs_pkg::S_IDLE;
      default:          state_next = apcs_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready  = (state == apcs_pkg::S_IDLE) && out_free;
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apcs_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == apcs_pkg::S_KIN && kin_done) begin
        cnt <= CW'(1);
      end else if (state == apcs_pkg::S_WALK) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed  <= apcs_pkg::MOVE_SPEED_RST;
      gravity     <= apcs_pkg::GRAVITY_RST;
      jump_speed  <= apcs_pkg::JUMP_SPEED_RST;
      half_width  <= apcs_pkg::HALF_WIDTH_RST;
      half_height <= apcs_pkg::HALF_HEIGHT_RST;
      half_depth  <= apcs_pkg::HALF_DEPTH_RST;
      box_count   <= apcs_pkg::BOX_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        apcs_pkg::REG_MOVE_SPEED:  move_speed  <= cfg_data[30:0];
        apcs_pkg::REG_GRAVITY:     gravity     <= cfg_data;
        apcs_pkg::REG_JUMP_SPEED:  jump_speed  <= cfg_data[30:0];
        apcs_pkg::REG_HALF_WIDTH:  half_width  <= cfg_data[30:0];
        apcs_pkg::REG_HALF_HEIGHT: half_height <= cfg_data[30:0];
        apcs_pkg::REG_HALF_DEPTH:  half_depth  <= cfg_data[30:0];
        apcs_pkg::REG_BOX_COUNT:   box_count   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Player state: jump acts at transfer, update when its result goes to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_speed <= '0;
      on_ground      <= 1'b0;
    end else if (acc && mode == apcs_pkg::MODE_JUMP && on_ground) begin
      vertical_speed <= $signed({1'b0, jump_speed});
      on_ground      <= 1'b0;
    end else if (state == apcs_pkg::S_DONE && out_free) begin
      vertical_speed <= res.vs;
      on_ground      <= res.gnd;
    end
  end

  // Capture the player leaving the last cell.
  always_ff @(posedge clk) begin
    if (state == apcs_pkg::S_WALK && cnt == CW'(MAX_BOXES)) begin
      res <= chain[MAX_BOXES];
    end
  end

  apcs_kin u_kin (
    .clk        (clk),
    .rst        (rst),
    .start      (acc && is_upd),
    .coord_x    (s_tdata[37:6]),
    .coord_y    (s_tdata[69:38]),
    .coord_z    (s_tdata[101:70]),
    .move_x     (s_tdata[213:198]),
    .move_z     (s_tdata[229:214]),
    .delta_t    (s_tdata[245:230]),
    .vs_in      (vertical_speed),
    .move_speed (move_speed),
    .gravity    (gravity),
    .done       (kin_done),
    .res        (kin_res)
  );

  assign chain[0] = kin_res;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    apcs_cell #(.IDX(i)) u_cell (
      .clk         (clk),
      .wr          (acc && mode == apcs_pkg::MODE_LOAD && 32'(slot) == i),
      .wr_box      (ld_box),
      .box_count   (box_count),
      .half_width  (half_width),
      .half_height (half_height),
      .half_depth  (half_depth),
      .pin         (chain[i]),
      .pout        (chain[i+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == apcs_pkg::S_DONE && out_free) begin
      out_px  <= res.px;
      out_py  <= res.py;
      out_pz  <= res.pz;
      out_vs  <= res.vs;
      out_gnd <= res.gnd;
    end else if (acc && !is_upd) begin
      out_px <= '0;
      out_py <= '0;
      out_pz <= '0;
      if (mode == apcs_pkg::MODE_JUMP && on_ground) begin
        out_vs  <= $signed({1'b0, jump_speed});
        out_gnd <= 1'b0;
      end else begin
        out_vs  <= vertical_speed;
        out_gnd <= on_ground;
      end
    end
  end

  assign m_tdata = {7'b0, out_gnd, out_vs, out_pz, out_py, out_px};

`include "aabb_player_collision_step_assert.svh"

  `APCS_ASSERT_NEXT(a_upd_starts, acc && is_upd, state == apcs_pkg::S_KIN, "update did not start")
  `APCS_ASSERT_NOW(a_walk_cnt, state == apcs_pkg::S_WALK, cnt != '0 && cnt <= CW'(MAX_BOXES), "walk count out of range")
  `APCS_ASSERT_NOW(a_gnd_speed, state == apcs_pkg::S_IDLE && on_ground, !vertical_speed[31], "grounded with downward speed")
  `APCS_ASSERT_NEXT(a_done_out, state == apcs_pkg::S_DONE && out_free, m_tvalid, "result not presented")

endmodule

[design/apcs_kin.sv]
// Kinematics pipeline: speeds, gravity and position advance.
module apcs_kin (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_y,
  input  logic signed [31:0]   coord_z,
  input  logic signed [15:0]   move_x,
  input  logic signed [15:0]   move_z,
  input  logic [15:0]          delta_t,
  input  logic signed [31:0]   vs_in,
  input  logic [30:0]          move_speed,
  input  logic signed [31:0]   gravity,
  output logic                 done,
  output apcs_pkg::player_t    res
);

  logic [4:0]         vld;
  logic signed [31:0] px, py, pz, vs0;
  logic signed [15:0] mx, mz;
  logic signed [16:0] dt;
  logic signed [47:0] mpx, mpz;
  logic signed [48:0] gp;
  logic signed [32:0] vx, vz;
  logic signed [31:0] vs_n;
  logic signed [49:0] qx, qz;
  logic signed [48:0] qy;
  logic signed [35:0] vs_sum;
  logic signed [35:0] sx, sy, sz;
  logic signed [31:0] rx, ry, rz;

  // Mark the result valid once the last stage has registered it.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  // Capture the item, then hold it for the pipeline.
  always_ff @(posedge clk) begin
    if (start) begin
      px  <= coord_x;
      py  <= coord_y;
      pz  <= coord_z;
      mx  <= move_x;
      mz  <= move_z;
      dt  <= {1'b0, delta_t};
      vs0 <= vs_in;
    end
  end

  assign vs_sum = {{4{vs0[31]}}, vs0} + {{3{gp[48]}}, gp[48:16]};
  assign sx     = {{4{px[31]}}, px} + {{2{qx[49]}}, qx[49:16]};
  assign sy     = {{4{py[31]}}, py} + {{3{qy[48]}}, qy[48:16]};
  assign sz     = {{4{pz[31]}}, pz} + {{2{qz[49]}}, qz[49:16]};

  always_ff @(posedge clk) begin
    mpx  <= mx * $signed({1'b0, move_speed});
    mpz  <= mz * $signed({1'b0, move_speed});
    gp   <= gravity * dt;
    vx   <= mpx[47:15];
    vz   <= mpz[47:15];
    vs_n <= apcs_pkg::sat32(vs_sum);
    qx   <= vx * dt;
    qz   <= vz * dt;
    qy   <= vs_n * dt;
    rx   <= apcs_pkg::sat32(sx);
    ry   <= apcs_pkg::sat32(sy);
    rz   <= apcs_pkg::sat32(sz);
  end

  assign done    = vld[4];
  assign res.px  = rx;
  assign res.py  = ry;
  assign res.pz  = rz;
  assign res.vs  = vs_n;
  assign res.gnd = 1'b0;

endmodule

[design/apcs_cell.sv]
// One box cell: holds a box and pushes the passing player out of it.
module apcs_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               wr,
  input  apcs_pkg::box_t     wr_box,
  input  logic [6:0]         box_count,
  input  logic [30:0]        half_width,
  input  logic [30:0]        half_height,
  input  logic [30:0]        half_depth,
  input  apcs_pkg::player_t  pin,
  output apcs_pkg::player_t  pout
);

  apcs_pkg::box_t    bx;
  apcs_pkg::player_t nxt;
  logic               en, hit, sel_x, sel_y, up_x, up_y, up_z;
  logic signed [33:0] lx, ux, ly, uy, lz, uz;
  logic signed [33:0] bnx, bxx, bny, bxy, bnz, bxz;
  logic signed [33:0] ax, bxl, ay, byl, az, bzl;
  logic signed [34:0] ox, oy, oz;
  logic signed [33:0] p2x, p2y, p2z, mdx, mdy, mdz;
  logic signed [35:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (wr) begin
      bx <= wr_box;
    end
  end

  assign en = 32'(box_count) > IDX;

  always_comb begin
    bnx = {{2{bx.min_x[31]}}, bx.min_x};
    bxx = {{2{bx.max_x[31]}}, bx.max_x};
    bny = {{2{bx.min_y[31]}}, bx.min_y};
    bxy = {{2{bx.max_y[31]}}, bx.max_y};
    bnz = {{2{bx.min_z[31]}}, bx.min_z};
    bxz = {{2{bx.max_z[31]}}, bx.max_z};
    lx = {{2{pin.px[31]}}, pin.px} - {3'b000, half_width};
    ux = {{2{pin.px[31]}}, pin.px} + {3'b000, half_width};
    ly = {{2{pin.py[31]}}, pin.py} - {3'b000, half_height};
    uy = {{2{pin.py[31]}}, pin.py} + {3'b000, half_height};
    lz = {{2{pin.pz[31]}}, pin.pz} - {3'b000, half_depth};
    uz = {{2{pin.pz[31]}}, pin.pz} + {3'b000, half_depth};
    hit = en && lx < bxx && ux > bnx && ly < bxy && uy > bny && lz < bxz && uz > bnz;
    ax  = (ux < bxx) ? ux : bxx;
    bxl = (lx > bnx) ? lx : bnx;
    ay  = (uy < bxy) ? uy : bxy;
    byl = (ly > bny) ? ly : bny;
    az  = (uz < bxz) ? uz : bxz;
    bzl = (lz > bnz) ? lz : bnz;
    ox = {ax[33], ax} - {bxl[33], bxl};
    oy = {ay[33], ay} - {byl[33], byl};
    oz = {az[33], az} - {bzl[33], bzl};
    sel_x = ox <= oy && ox <= oz;
    sel_y = oy <= ox && oy <= oz;
    // Centre test as 2*p > min+max, exact.
    p2x = {pin.px[31], pin.px, 1'b0};
    p2y = {pin.py[31], pin.py, 1'b0};
    p2z = {pin.pz[31], pin.pz, 1'b0};
    mdx = bnx + bxx;
    mdy = bny + bxy;
    mdz = bnz + bxz;
    up_x = p2x > mdx;
    up_y = p2y > mdy;
    up_z = p2z > mdz;
    sx = up_x ? {{4{pin.px[31]}}, pin.px} + {ox[34], ox}
              : {{4{pin.px[31]}}, pin.px} - {ox[34], ox};
    sy = up_y ? {{4{pin.py[31]}}, pin.py} + {oy[34], oy}
              : {{4{pin.py[31]}}, pin.py} - {oy[34], oy};
    sz = up_z ? {{4{pin.pz[31]}}, pin.pz} + {oz[34], oz}
              : {{4{pin.pz[31]}}, pin.pz} - {oz[34], oz};
    nxt = pin;
    if (hit) begin
      if (sel_x) begin
        nxt.px = apcs_pkg::sat32(sx);
      end else if (sel_y) begin
        nxt.py = apcs_pkg::sat32(sy);
        if (up_y) begin
          nxt.gnd = 1'b1;
          if (pin.vs < 0) nxt.vs = '0;
        end else begin
          if (pin.vs > 0) nxt.vs = '0;
        end
      end else begin
        nxt.pz = apcs_pkg::sat32(sz);
      end
    end
  end

  // Hand the player to the neighbor every cycle.
  always_ff @(posedge clk) begin
    pout <= nxt;
  end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the player collision step: stimulus, predictor and checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE        = 65536;      // 1.0 in Q16.16
  localparam int     CYCLE_CAP  = 1000000;    // generous run limit
  localparam int     DRAIN_WAIT = 100;        // longer than one update
  localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode code

  typedef struct {
    logic [1:0]         mode;
    logic [5:0]         slot;
    logic signed [31:0] cx, cy, cz;
    logic signed [31:0] ux, uy, uz;
    logic signed [15:0] mx, mz;
    logic [15:0]        dt;
  } item_t;

  typedef struct {
    logic [31:0] px, py, pz, vy;
    logic        gnd;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [1:0] s_tuser = '0;       // mode
  // slot, coord_x, coord_y, coord_z, upper_x, upper_y, upper_z,
  // move_x, move_z, delta_t, zero pad
  logic [247:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // pos_x, pos_y, pos_z, vel_y, grounded, zero pad
  logic [135:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  aabb_player_collision_step dut (.*);

  always #5 clk = ~clk;

  // Predictor state: player speed, grounded flag, box table, register copies.
  longint vspeed;
  bit     standing;
  longint tbl_lx[64], tbl_ly[64], tbl_lz[64], tbl_hx[64], tbl_hy[64], tbl_hz[64];
  longint r_move, r_grav, r_jump, r_hw, r_hh, r_hd, r_count;

  item_t  pending[$];
  pose_t  expected_poses[$];
  item_t  cur;
  int     errors = 0;
  int     cycles = 0;
  int     n_results = 0, n_updates = 0, n_pushes = 0, n_cfg = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Advance the player by one item and return the pose it reports.
  function automatic pose_t step_player(item_t it);
    pose_t  r;
    longint px = 0, py = 0, pz = 0, dt, mxv, mzv, vx, vz;
    longint lx, hx, ly, hy, lz, hz, ox, oy, oz;
    int     n;
    case (it.mode)
      apcs_pkg::MODE_UPDATE: begin
        n_updates++;
        dt  = longint'({48'd0, it.dt});
        mxv = it.mx;
        mzv = it.mz;
        vx = (mxv * r_move) >>> 15;
        vz = (mzv * r_move) >>> 15;
        px = it.cx;
        py = it.cy;
        pz = it.cz;
        vspeed = clamp32(vspeed + ((r_grav * dt) >>> 16));
        px = clamp32(px + ((vx * dt) >>> 16));
        py = clamp32(py + ((vspeed * dt) >>> 16));
        pz = clamp32(pz + ((vz * dt) >>> 16));
        n = (r_count > 64) ? 64 : int'(r_count);
        standing = 1'b0;
        for (int i = 0; i < n; i++) begin
          lx = px - r_hw; hx = px + r_hw;
          ly = py - r_hh; hy = py + r_hh;
          lz = pz - r_hd; hz = pz + r_hd;
          if (!(lx < tbl_hx[i] && hx > tbl_lx[i] && ly < tbl_hy[i] && hy > tbl_ly[i] &&
                lz < tbl_hz[i] && hz > tbl_lz[i]))
            continue;
          n_pushes++;
          ox = ((hx < tbl_hx[i]) ? hx : tbl_hx[i]) - ((lx > tbl_lx[i]) ? lx : tbl_lx[i]);
          oy = ((hy < tbl_hy[i]) ? hy : tbl_hy[i]) - ((ly > tbl_ly[i]) ? ly : tbl_ly[i]);
          oz = ((hz < tbl_hz[i]) ? hz : tbl_hz[i]) - ((lz > tbl_lz[i]) ? lz : tbl_lz[i]);
          // Least overlap wins; ties go to X, then Y, then Z.
          if (ox <= oy && ox <= oz) begin
            px = clamp32((2 * px > tbl_lx[i] + tbl_hx[i]) ? px + ox : px - ox);
          end else if (oy <= ox && oy <= oz) begin
            if (2 * py > tbl_ly[i] + tbl_hy[i]) begin
              py = clamp32(py + oy);
              if (vspeed < 0) vspeed = 0;
              standing = 1'b1;
            end else begin
              py = clamp32(py - oy);
              if (vspeed > 0) vspeed = 0;
            end
          end else begin
            pz = clamp32((2 * pz > tbl_lz[i] + tbl_hz[i]) ? pz + oz : pz - oz);
          end
        end
      end
      apcs_pkg::MODE_JUMP: begin
        if (standing) begin
          vspeed   = r_jump;
          standing = 1'b0;
        end
      end
      apcs_pkg::MODE_LOAD: begin
        tbl_lx[it.slot] = it.cx; tbl_ly[it.slot] = it.cy; tbl_lz[it.slot] = it.cz;
        tbl_hx[it.slot] = it.ux; tbl_hy[it.slot] = it.uy; tbl_hz[it.slot] = it.uz;
      end
      default: ;
    endcase
    r.px = px[31:0];
    r.py = py[31:0];
    r.pz = pz[31:0];
    r.vy = vspeed[31:0];
    r.gnd = standing;
    return r;
  endfunction

  // Register copies follow each configuration transfer.
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      n_cfg++;
      case (cfg_index)
        apcs_pkg::REG_MOVE_SPEED:  r_move  = longint'({33'd0, cfg_data[30:0]});
        apcs_pkg::REG_GRAVITY:     r_grav  = longint'($signed(cfg_data));
        apcs_pkg::REG_JUMP_SPEED:  r_jump  = longint'({33'd0, cfg_data[30:0]});
        apcs_pkg::REG_HALF_WIDTH:  r_hw    = longint'({33'd0, cfg_data[30:0]});
        apcs_pkg::REG_HALF_HEIGHT: r_hh    = longint'({33'd0, cfg_data[30:0]});
        apcs_pkg::REG_HALF_DEPTH:  r_hd    = longint'({33'd0, cfg_data[30:0]});
        apcs_pkg::REG_BOX_COUNT:   r_count = longint'({57'd0, cfg_data[6:0]});
        default: ;
      endcase
    end
  end

  // Driver: predict on each input transfer, then offer the next item in bursts.
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_poses.push_back(step_player(cur));
      if (s_tvalid && !s_tready) begin
        // hold the offered item until it transfers
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        cur = pending.pop_front();
        s_tuser <= cur.mode;
        s_tdata <= {2'b00, cur.dt, cur.mz, cur.mx, cur.uz, cur.uy, cur.ux,
                    cur.cz, cur.cy, cur.cx, cur.slot};
        s_tvalid <= 1'b1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          // long bursts with no gap now and then
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern drawn anew each window, plus one long hold-off.
  int  holdoff = 0;
  bit  held_once = 1'b0;
  int  stall_style = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (cycles % 512 == 0) stall_style = $urandom_range(0, 2);
      if (holdoff > 0) begin
        holdoff--;
        m_tready <= 1'b0;
      end else if (!held_once && n_results >= 300) begin
        held_once = 1'b1;
        holdoff = 3000;
        m_tready <= 1'b0;
      end else begin
        case (stall_style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each output transfer with the oldest predicted pose.
  always @(posedge clk) begin
    pose_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (expected_poses.size() == 0) begin
        errors++;
        $error("result with no prediction waiting: %h", m_tdata);
      end else begin
        e = expected_poses.pop_front();
        if (m_tdata[31:0] !== e.px) begin
          errors++; $error("pos_x expected %h actual %h", e.px, m_tdata[31:0]);
        end
        if (m_tdata[63:32] !== e.py) begin
          errors++; $error("pos_y expected %h actual %h", e.py, m_tdata[63:32]);
        end
        if (m_tdata[95:64] !== e.pz) begin
          errors++; $error("pos_z expected %h actual %h", e.pz, m_tdata[95:64]);
        end
        if (m_tdata[127:96] !== e.vy) begin
          errors++; $error("vel_y expected %h actual %h", e.vy, m_tdata[127:96]);
        end
        if (m_tdata[128] !== e.gnd) begin
          errors++; $error("grounded expected %b actual %b", e.gnd, m_tdata[128]);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic item_t mk(logic [1:0] mode, logic [5:0] slot,
                               longint cx, longint cy, longint cz,
                               longint ux, longint uy, longint uz,
                               longint mx, longint mz, longint dt);
    item_t it;
    it.mode = mode; it.slot = slot;
    it.cx = cx[31:0]; it.cy = cy[31:0]; it.cz = cz[31:0];
    it.ux = ux[31:0]; it.uy = uy[31:0]; it.uz = uz[31:0];
    it.mx = mx[15:0]; it.mz = mz[15:0]; it.dt = dt[15:0];
    return it;
  endfunction

  function automatic longint near(int units);
    return longint'($urandom_range(0, 2 * units * ONE)) - units * ONE;
  endfunction

  // A box somewhere in the arena, now and then inverted.
  function automatic item_t arena_box(logic [5:0] slot);
    longint c[3], h[3];
    for (int a = 0; a < 3; a++) begin
      c[a] = near(12);
      h[a] = $urandom_range(ONE / 8, 3 * ONE);
    end
    if ($urandom_range(0, 15) == 0) h[1] = -h[1];
    return mk(apcs_pkg::MODE_LOAD, slot, c[0] - h[0], c[1] - h[1], c[2] - h[2],
              c[0] + h[0], c[1] + h[1], c[2] + h[2], 0, 0, 0);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick = $urandom_range(0, 99);
    it = mk(apcs_pkg::MODE_UPDATE, 6'($urandom()), near(14), near(14), near(14),
            $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom_range(0, 8192));
    if (pick < 12) begin
      it.mode = apcs_pkg::MODE_JUMP;
    end else if (pick < 18) begin
      it = arena_box(6'($urandom_range(0, 63)));
    end else if (pick < 21) begin
      it.mode = MODE_SPARE;
    end else if (pick < 33) begin
      // noise: every field but the mode fully random
      it.cx = $urandom(); it.cy = $urandom(); it.cz = $urandom();
      it.dt = 16'($urandom());
      if ($urandom_range(0, 3) == 0) begin
        it.mode = apcs_pkg::MODE_LOAD;
        it.ux = $urandom(); it.uy = $urandom(); it.uz = $urandom();
      end
    end
    return it;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || s_tvalid || expected_poses.size() != 0);
  endtask

  function automatic logic [31:0] pick_extent();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'h7FFFFFFF;
      default: return $urandom_range(ONE / 10, 2 * ONE);
    endcase
  endfunction

  initial begin
    longint mx32 = 64'sd2147483647, mn32 = -64'sd2147483648;
    logic [31:0] v;
    vspeed = 0; standing = 1'b0;
    r_move = apcs_pkg::MOVE_SPEED_RST; r_grav = apcs_pkg::GRAVITY_RST;
    r_jump = apcs_pkg::JUMP_SPEED_RST;
    r_hw = apcs_pkg::HALF_WIDTH_RST; r_hh = apcs_pkg::HALF_HEIGHT_RST;
    r_hd = apcs_pkg::HALF_DEPTH_RST;
    r_count = apcs_pkg::BOX_COUNT_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table first, extremes, jump while airborne, unused mode.
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 63, mx32, mx32, mx32, -1, -1, -1,
                         32767, 32767, 65535));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, mn32, mn32, mn32, 0, 0, 0,
                         -32768, -32768, 65535));
    pending.push_back(mk(apcs_pkg::MODE_JUMP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(MODE_SPARE, 0, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    // floor, ties X/Y/Z, tie X/Y, tie Y/Z, inverted, touching, ceiling, saturating box
    pending.push_back(mk(apcs_pkg::MODE_LOAD, 0, -8*ONE, -ONE, -8*ONE, 8*ONE, 0, 8*ONE,
                         0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_LOAD, 1, 21*ONE/2, ONE/2, ONE/2, 12*ONE, 2*ONE,
                         2*ONE, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_LOAD, 2, 41*ONE/2, ONE/2, -2*ONE, 22*ONE, 2*ONE,
                         2*ONE, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_LOAD, 3, 28*ONE, ONE/2, ONE/2, 32*ONE, 2*ONE,
                         2*ONE, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_LOAD, 4, 81*ONE/2, ONE/2, ONE/2, 398*ONE/10,
                         -ONE/2, -ONE/2, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_LOAD, 5, 51*ONE, -ONE, -ONE, 53*ONE, ONE, ONE,
                         0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_LOAD, 6, 56*ONE, 3*ONE/2, -4*ONE, 64*ONE, 3*ONE,
                         4*ONE, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_LOAD, 7, 64'sh7FFF0000, 64'sh7FFF0000,
                         64'sh7FFF0000, mx32, mx32, mx32, 0, 0, 0));
    wait_idle();
    write_reg(apcs_pkg::REG_HALF_WIDTH, 32'(ONE));
    write_reg(apcs_pkg::REG_HALF_HEIGHT, 32'(ONE));
    write_reg(apcs_pkg::REG_HALF_DEPTH, 32'(ONE));
    write_reg(apcs_pkg::REG_BOX_COUNT, 32'd8);
    // land on the floor, jump, touch, hit the ceiling, tie breaks, inverted, saturate
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 0, ONE/2, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_JUMP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 50*ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 60*ONE, ONE, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 10*ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 20*ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 30*ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 40*ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 64'sh7FFF8000, 64'sh7FFF8000,
                         64'sh7FFF8000, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(apcs_pkg::MODE_UPDATE, 0, 0, ONE/2, 0, 0, 0, 0, 16384, -16384,
                         4096));

    // Fill the whole table with arena boxes before random phases.
    for (int s = 0; s < 64; s++) pending.push_back(arena_box(6'(s)));

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      case (ph)
        0: v = 0;
        1: v = 32'h7FFFFFFF;
        default: v = $urandom_range(0, 4 * 327680);
      endcase
      write_reg(apcs_pkg::REG_MOVE_SPEED, v);
      case (ph)
        0: v = 32'h80000000;
        1: v = 32'h7FFFFFFF;
        2: v = 0;
        default: v = -$urandom_range(0, 2 * 642253);
      endcase
      write_reg(apcs_pkg::REG_GRAVITY, v);
      write_reg(apcs_pkg::REG_JUMP_SPEED, (ph == 1) ? 32'h7FFFFFFF : (ph == 0) ? 32'd0 :
                                 $urandom_range(0, 4 * 327680));
      write_reg(apcs_pkg::REG_HALF_WIDTH, pick_extent());
      write_reg(apcs_pkg::REG_HALF_HEIGHT, pick_extent());
      write_reg(apcs_pkg::REG_HALF_DEPTH, pick_extent());
      case (ph)
        0: v = 0;
        1: v = 127;
        2: v = 64;
        default: v = $urandom_range(1, 100);
      endcase
      write_reg(apcs_pkg::REG_BOX_COUNT, v);
      for (int k = 0; k < 110; k++) pending.push_back(random_item());
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_poses.size() != 0) begin
      errors++;
      $error("%0d predicted poses never arrived", expected_poses.size());
    end
    $display("Covered %0d results, %0d updates with %0d box pushes, %0d register writes.",
             n_results, n_updates, n_pushes, n_cfg);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[aabb_player_collision_step.f]
+incdir+design
design/apcs_pkg.sv
design/apcs_kin.sv
design/apcs_cell.sv
design/aabb_player_collision_step.sv
tb/sv/testbench.sv
